@@ sv/assert_macros.svh @@
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, active outside reset
`define CHK_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed");

// implication check, active outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

`endif

@@ sv/tkht_pkg.sv @@
package tkht_pkg;

    localparam logic [2:0] ST_REJECT = 3'd0;
    localparam logic [2:0] ST_INSERT = 3'd1;
    localparam logic [2:0] ST_IMPROVE = 3'd2;
    localparam logic [2:0] ST_COUNT = 3'd3;
    localparam logic [2:0] ST_READ = 3'd4;

    typedef struct packed {
        logic        action;
        logic [31:0] protein_key;
        logic signed [15:0] score;
        logic [15:0] match_length;
        logic [39:0] suffix_pos;
        logic [5:0]  rank_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        evicted_valid;
        logic [31:0] evicted_key;
        logic        entry_valid;
        logic [31:0] entry_key;
        logic signed [15:0] entry_score;
        logic [15:0] entry_length;
        logic [31:0] entry_count;
        logic        entry_multiple;
        logic [6:0]  list_size;
    } out_item_t;

    typedef struct packed {
        logic [31:0] key;
        logic signed [15:0] score;
        logic [15:0] length;
        logic [31:0] count;
        logic [39:0] first_pos;
        logic        multiple;
    } slot_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic  shift_up;    // ranks at/after lo take from the rank below
        logic  shift_down;  // ranks after ins take from the rank above
        logic  write_new;   // rank ins takes new_slot
        slot_t new_slot;
    } cell_cmd_t;

endpackage

@@ sv/tkht_cell.sv @@
module tkht_cell
    import tkht_pkg::*;
#(
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic [IDX_W-1:0] my_rank,
    input  logic [IDX_W-1:0] lo,
    input  logic [IDX_W-1:0] ins,
    input  logic [IDX_W:0]   total,
    input  cell_cmd_t        cmd,
    input  slot_t            from_above,
    input  slot_t            from_below,
    input  logic [31:0]      key,
    input  logic signed [15:0] score,
    output slot_t            slot,
    output logic             key_hit,
    output logic             ge_score
);

    slot_t slot_reg;
    slot_t slot_next;
    logic  live;

    assign live = ({1'b0, my_rank} < total);

    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.shift_up && my_rank >= lo)
        begin
            slot_next = from_below;
        end
        if (cmd.shift_down && my_rank > ins)
        begin
            slot_next = from_above;
        end
        if (cmd.write_new && my_rank == ins)
        begin
            slot_next = cmd.new_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot     = slot_reg;
    assign key_hit  = live && (slot_reg.key == key);
    assign ge_score = live && (slot_reg.score >= score);

endmodule

@@ sv/top_k_hit_table_core.sv @@
// top-k hit table with one entry per key
// input channel: in_valid/in_stall with in_data; offers (action 0) and rank reads
// (action 1). output channel: out_valid/out_stall with out_data, one result per
// input item. config channel: cfg_valid/cfg_ready carries capacity (1..MAX_ENTRIES,
// out of range values clamp); a write is dropped while the table holds entries.
// entries live in a chain of cells in rank order; every cell compares its key and
// score with the offer in parallel, and shifts move entries between neighbors.
// every item walks capture, search, remove shift, insert shift, in that order.
// reads, rejects and count-only offers reach the result register at the end of the
// search state, the cycle after the transfer in; inserts and improvements at the
// end of the insert shift. a count-only offer is written back in place during the
// insert shift cycle. the next item is taken once the machine is idle again and the
// result register has been emptied or is being taken, so no item is taken before
// the last is through. the result register holds while out_stall is high. reset
// empties the table, sets capacity to 10 (or MAX_ENTRIES if less); no clearing pass.
`include "assert_macros.svh"
module top_k_hit_table_core
    import tkht_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [6:0] cfg_data
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_EVCT = 2'd2;
    localparam logic [1:0] S_INS  = 2'd3;

    logic [1:0]       state_reg, state_next;
    in_item_t         item_reg;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] cap_reg;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg;
    out_item_t        srch_out, ins_out;
    logic [IDX_W-1:0] lo_reg, ins_reg;
    slot_t            new_reg, new_next;
    logic             rm_reg, ins_en_reg, cnt_reg;

    slot_t      slots [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] hit_vec, ge_vec;
    cell_cmd_t  cmd;
    logic [IDX_W-1:0] lo_w, ins_w;
    logic [IDX_W-1:0] ins_calc;
    logic [IDX_W-1:0] sel_idx;

    logic is_read, reject, is_count, is_ins, is_rm;

    logic in_xfer, out_free;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign in_xfer  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // lowest set hit index
    logic             found;
    logic [IDX_W-1:0] hit_idx;
    always_comb
    begin
        found = 1'b0;
        hit_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                found = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // insert rank: ge flags form a run from rank 0, so take the first clear one
    always_comb
    begin
        ins_calc = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!ge_vec[i])
            begin
                ins_calc = IDX_W'(i);
            end
        end
    end

    logic             full;
    logic [CNT_W-1:0] last_w;
    slot_t            worst, hit_s, upd;
    assign full    = (total_reg >= cap_reg) && (total_reg != '0);
    assign last_w  = total_reg - CNT_W'(1);
    assign worst   = slots[last_w[IDX_W-1:0]];
    assign sel_idx = item_reg.action ? item_reg.rank_index[IDX_W-1:0] : hit_idx;
    assign hit_s   = slots[sel_idx];

    always_comb
    begin
        upd = hit_s;
        if (hit_s.count != 32'hFFFF_FFFF)
        begin
            upd.count = hit_s.count + 32'd1;
        end
        if (!hit_s.multiple && item_reg.suffix_pos != hit_s.first_pos)
        begin
            upd.multiple = 1'b1;
        end
    end

    assign is_read  = item_reg.action;
    assign reject   = full && (worst.score >= item_reg.score);
    assign is_count = !is_read && !reject && found && (hit_s.score >= item_reg.score);
    assign is_ins   = !is_read && !reject && !is_count;
    assign is_rm    = is_ins && (found || full);

    function automatic out_item_t put(input slot_t s, input logic [2:0] st,
                                      input logic [CNT_W-1:0] n);
        out_item_t o;
        o = '0;
        o.status = st;
        o.entry_valid = 1'b1;
        o.entry_key = s.key;
        o.entry_score = s.score;
        o.entry_length = s.length;
        o.entry_count = s.count;
        o.entry_multiple = s.multiple;
        o.list_size = 7'(n);
        return o;
    endfunction

    always_comb
    begin
        cmd = '0;
        cmd.new_slot = new_reg;
        lo_w = lo_reg;
        ins_w = ins_reg;
        if (state_reg == S_EVCT && rm_reg)
        begin
            cmd.shift_up = 1'b1;
        end
        if (state_reg == S_INS && ins_en_reg)
        begin
            cmd.shift_down = 1'b1;
            cmd.write_new = 1'b1;
        end
        if (state_reg == S_INS && cnt_reg)
        begin
            cmd.write_new = 1'b1;
        end
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        slot_t above, below;
        if (g == 0)
        begin : g_top
            assign above = slots[0];
        end
        else
        begin : g_mid
            assign above = slots[g-1];
        end
        if (g == MAX_ENTRIES - 1)
        begin : g_bot
            assign below = slots[g];
        end
        else
        begin : g_low
            assign below = slots[g+1];
        end
        tkht_cell #(.IDX_W(IDX_W)) u_cell (
            .clk        (clk),
            .my_rank    (IDX_W'(g)),
            .lo         (lo_w),
            .ins        (ins_w),
            .total      ((IDX_W+1)'(total_reg)),
            .cmd        (cmd),
            .from_above (above),
            .from_below (below),
            .key        (item_reg.protein_key),
            .score      (item_reg.score),
            .slot       (slots[g]),
            .key_hit    (hit_vec[g]),
            .ge_score   (ge_vec[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_xfer) state_next = S_SRCH;
            S_SRCH: state_next = S_EVCT;
            S_EVCT: state_next = S_INS;
            S_INS:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // result of the search cycle
    always_comb
    begin
        srch_out = '0;
        srch_out.list_size = 7'(total_reg);
        if (is_read)
        begin
            srch_out.status = ST_READ;
            if ({1'b0, item_reg.rank_index} < (IDX_W+1)'(total_reg))
            begin
                srch_out = put(hit_s, ST_READ, total_reg);
            end
        end
        else if (reject)
        begin
            srch_out = put(worst, ST_REJECT, total_reg);
        end
        else if (is_count)
        begin
            srch_out = put(upd, ST_COUNT, total_reg);
        end
        else if (found)
        begin
            srch_out.status = ST_IMPROVE;
        end
        else
        begin
            srch_out.status = ST_INSERT;
            if (full)
            begin
                srch_out.evicted_valid = 1'b1;
                srch_out.evicted_key = worst.key;
            end
        end
    end

    always_comb
    begin
        ins_out = out_reg;
        ins_out.entry_valid = 1'b1;
        ins_out.entry_key = new_reg.key;
        ins_out.entry_score = new_reg.score;
        ins_out.entry_length = new_reg.length;
        ins_out.entry_count = new_reg.count;
        ins_out.entry_multiple = new_reg.multiple;
        ins_out.list_size = 7'(total_reg + CNT_W'(1));
    end

    always_comb
    begin
        new_next = slot_t'{item_reg.protein_key, item_reg.score,
            item_reg.match_length, 32'd1, item_reg.suffix_pos, 1'b0};
        if (found)
        begin
            new_next = upd;
            if (!is_count)
            begin
                new_next.score = item_reg.score;
                new_next.length = item_reg.match_length;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_SRCH && !is_ins)
        begin
            out_valid_next = 1'b1;
        end
        if (state_reg == S_INS && ins_en_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            cap_reg <= (10 > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : CNT_W'(10);
            out_valid_reg <= 1'b0;
            rm_reg <= 1'b0;
            ins_en_reg <= 1'b0;
            cnt_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && total_reg == '0)
            begin
                if (cfg_data == 7'd0)
                begin
                    cap_reg <= CNT_W'(1);
                end
                else if (32'(cfg_data) > 32'(MAX_ENTRIES))
                begin
                    cap_reg <= CNT_W'(MAX_ENTRIES);
                end
                else
                begin
                    cap_reg <= CNT_W'(cfg_data);
                end
            end
            if (state_reg == S_SRCH)
            begin
                rm_reg <= is_rm;
                ins_en_reg <= is_ins;
                cnt_reg <= is_count;
                if (is_rm)
                begin
                    total_reg <= total_reg - CNT_W'(1);
                end
            end
            if (state_reg == S_INS && ins_en_reg)
            begin
                total_reg <= total_reg + CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= in_data;
        end
        if (state_reg == S_SRCH)
        begin
            out_reg <= srch_out;
            new_reg <= new_next;
            if (found)
            begin
                lo_reg <= hit_idx;
            end
            else
            begin
                lo_reg <= last_w[IDX_W-1:0];
            end
        end
        else if (state_reg == S_INS && ins_en_reg)
        begin
            out_reg <= ins_out;
        end
        if (state_reg == S_EVCT)
        begin
            // count-only offers are written back at their own rank
            ins_reg <= cnt_reg ? lo_reg : ins_calc;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `CHK_IMPL(a_cap_bound, clk, rst_n, 1'b1, total_reg <= CNT_W'(MAX_ENTRIES))
    `CHK_IMPL(a_busy_stall, clk, rst_n, state_reg != S_IDLE, in_stall)
    `CHK_ALWAYS(a_cap_nz, clk, rst_n, cap_reg != '0)

endmodule

@@ verif/tb_top_k_hit_table_core.sv @@
module tb_top_k_hit_table_core;
    import tkht_pkg::*;

    localparam int MAX_E = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [6:0] cfg_data = '0;

    top_k_hit_table_core #(.MAX_ENTRIES(MAX_E)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // shadow of the hit table, rank order
    slot_t     rank_slot[MAX_E];
    int        held_total;
    int        cap_limit;
    out_item_t pending_results[$];
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    longint    cycle_count = 0;

    // key pool kept small so known keys get hit often
    logic [31:0] key_pool[16];

    function automatic int clamp_capacity(input logic [6:0] v);
        if (v == 0) return 1;
        if (v > MAX_E) return MAX_E;
        return int'(v);
    endfunction

    function automatic void drop_rank(input int p);
        for (int i = p; i + 1 < held_total; i++) rank_slot[i] = rank_slot[i + 1];
        held_total--;
    endfunction

    function automatic int place_slot(input slot_t s);
        int p;
        p = 0;
        while (p < held_total && rank_slot[p].score >= s.score) p++;
        for (int i = held_total; i > p; i--) rank_slot[i] = rank_slot[i - 1];
        rank_slot[p] = s;
        held_total++;
        return p;
    endfunction

    function automatic void fill_entry(inout out_item_t o, input int r);
        o.entry_valid    = 1'b1;
        o.entry_key      = rank_slot[r].key;
        o.entry_score    = rank_slot[r].score;
        o.entry_length   = rank_slot[r].length;
        o.entry_count    = rank_slot[r].count;
        o.entry_multiple = rank_slot[r].multiple;
    endfunction

    function automatic out_item_t predict_hit(input in_item_t it);
        out_item_t o;
        slot_t s;
        int idx;
        int r;
        o = '0;
        idx = -1;
        if (it.action) begin
            o.status = ST_READ;
            if (it.rank_index < held_total) fill_entry(o, it.rank_index);
            o.list_size = 7'(held_total);
            return o;
        end
        if (held_total >= cap_limit && held_total > 0 &&
            rank_slot[held_total - 1].score >= it.score) begin
            o.status = ST_REJECT;
            fill_entry(o, held_total - 1);
            o.list_size = 7'(held_total);
            return o;
        end
        for (int i = 0; i < held_total; i++)
            if (idx < 0 && rank_slot[i].key == it.protein_key) idx = i;
        if (idx < 0) begin
            if (held_total >= cap_limit && held_total > 0) begin
                o.evicted_valid = 1'b1;
                o.evicted_key = rank_slot[held_total - 1].key;
                drop_rank(held_total - 1);
            end
            s.key = it.protein_key;
            s.score = it.score;
            s.length = it.match_length;
            s.count = 1;
            s.first_pos = it.suffix_pos;
            s.multiple = 1'b0;
            r = place_slot(s);
            o.status = ST_INSERT;
        end else begin
            s = rank_slot[idx];
            if (s.count != 32'hFFFF_FFFF) s.count++;
            if (it.suffix_pos != s.first_pos) s.multiple = 1'b1;
            if (s.score < it.score) begin
                s.score = it.score;
                s.length = it.match_length;
                drop_rank(idx);
                r = place_slot(s);
                o.status = ST_IMPROVE;
            end else begin
                rank_slot[idx] = s;
                r = idx;
                o.status = ST_COUNT;
            end
        end
        fill_entry(o, r);
        o.list_size = 7'(held_total);
        return o;
    endfunction

    // valid stays high between items sent back to back; it drops on idle or drain
    task automatic send_hit(input in_item_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_results.push_back(predict_hit(it));
    endtask

    // a stalled count on the forced-saturation path is not reachable; count limit
    // is checked by the predictor's arithmetic only
    always @(posedge clk) begin
        out_item_t exp_r;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) $display("unexpected result %p", out_data);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (out_data !== exp_r) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch exp %p got %p", exp_r, out_data);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [6:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (held_total == 0) cap_limit = clamp_capacity(v);
    endtask

    function automatic in_item_t offer_item(input logic [31:0] k, input int sc,
                                            input logic [15:0] len,
                                            input logic [39:0] pos);
        in_item_t it;
        it = '0;
        it.protein_key = k;
        it.score = 16'(sc);
        it.match_length = len;
        it.suffix_pos = pos;
        return it;
    endfunction

    function automatic in_item_t read_item(input int r);
        in_item_t it;
        it = '0;
        it.action = 1'b1;
        it.rank_index = 6'(r);
        it.protein_key = $urandom();
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it.action = ($urandom_range(9) < 2);
        it.protein_key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(15)];
        it.score = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(40)) - 16'd20;
        it.match_length = 16'($urandom());
        it.suffix_pos = ($urandom_range(3) == 0) ? {8'($urandom()), 32'($urandom())}
                                                 : 40'($urandom_range(3));
        it.rank_index = 6'($urandom());
        return it;
    endfunction

    // reads once, offers and then reads the table out; reading does not empty it - no clear exists,
    // so later tests run on the table this one leaves, not on a fresh one
    task automatic test_directed();
        send_hit(read_item(0));
        send_hit(offer_item(32'hFFFF_FFFF, 32767, 16'hFFFF, 40'hFF_FFFF_FFFF));
        send_hit(offer_item(32'h0, -32768, 16'h0, 40'h0));
        send_hit(offer_item(32'h5, 0, 16'd10, 40'd7));
        send_hit(offer_item(32'h5, 0, 16'd99, 40'd7));
        send_hit(offer_item(32'h5, 0, 16'd99, 40'd8));
        send_hit(offer_item(32'h6, 0, 16'd3, 40'd1));
        send_hit(offer_item(32'h0, 5, 16'd4, 40'd2));
        for (int i = 0; i < 10; i++) send_hit(offer_item(32'h100 + i, i - 3, 16'(i), 40'(i)));
        send_hit(offer_item(32'h200, -32768, 16'd1, 40'd1));
        send_hit(offer_item(32'h201, 100, 16'd1, 40'd1));
        for (int i = 0; i < 12; i++) send_hit(read_item(i == 11 ? 63 : i));
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) begin
            send_hit(random_item());
            if (i == n / 2) drain_results();
        end
    endtask

    task automatic test_capacity_locked();
        write_capacity(7'd3);
        send_hit(offer_item(32'h77, 1, 16'd1, 40'd1));
    endtask

    initial begin
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        held_total = 0;
        cap_limit = 10;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_capacity(7'd0);
        write_capacity(7'd127);
        write_capacity(7'd10);
        send_idle_pct = 25;
        recv_stall_pct = 55;
        test_directed();
        test_capacity_locked();
        test_random(240);
        send_idle_pct = 55;
        recv_stall_pct = 25;
        test_random(240);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(200);
        drain_results();
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
